// ===== rtl/core/dtfd_pkg.sv =====
// Shared constants, codes and types for the timestamped frame delay meter.
package dtfd_pkg;

   // Largest frame in bytes before an overflow drop.
   localparam int MAX_FRAME = 4096;

   // Field widths fixed by the interface.
   localparam int BYTE_W      = 8;
   localparam int TIME_W      = 64;
   localparam int STATUS_W    = 2;
   localparam int FRAME_LEN_W = 13;
   localparam int SEQ_W       = 32;
   localparam int CSR_LEN_W   = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   // The origin timestamp occupies the first bytes of every frame.
   localparam int STAMP_BYTES = TIME_W / BYTE_W;

   // Position within a frame holds 0 .. MAX_FRAME-1; a length holds up to MAX_FRAME.
   localparam int POS_W = $clog2(MAX_FRAME);
   localparam int LEN_W = POS_W + 1;
   localparam int CMP_W = (LEN_W > CSR_LEN_W) ? LEN_W : CSR_LEN_W;

   // Register reset values.
   localparam logic [CSR_LEN_W-1:0] MIN_LENGTH_RESET = CSR_LEN_W'(509);
   localparam logic [CSR_LEN_W-1:0] MAX_LENGTH_RESET = CSR_LEN_W'(1009);
   localparam logic [BYTE_W-1:0]    DELIMITER_RESET  = BYTE_W'(124);

   // Register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MIN_LENGTH = 2'd0,
      CSR_MAX_LENGTH = 2'd1,
      CSR_DELIMITER  = 2'd2
   } csr_index_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_MEASURE    = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_OVERFLOW   = 2'd2
   } status_type;

   // Configuration as seen by the frame logic.
   typedef struct packed {
      logic [CSR_LEN_W-1:0] min_length;
      logic [CSR_LEN_W-1:0] max_length;
      logic [BYTE_W-1:0]    delimiter;
   } cfg_type;

   // Registered input item.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data_byte;
      logic [TIME_W-1:0] arrival_time_us;
   } in_item_type;

   // Result produced by the frame logic.
   typedef struct packed {
      logic                   valid;
      logic [STATUS_W-1:0]    status;
      logic [TIME_W-1:0]      delay_us;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [SEQ_W-1:0]       sequence_res;
   } result_type;

endpackage

// ===== rtl/core/dtfd_req_if.sv =====
// Input channel: one stream byte with its arrival time per transfer.
interface dtfd_req_if
   import dtfd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic [TIME_W-1:0] arrival_time_us;

   modport source (output valid, output data_byte, output arrival_time_us, input ready);
   modport sink   (input valid, input data_byte, input arrival_time_us, output ready);
endinterface

// ===== rtl/core/dtfd_rsp_if.sv =====
// Result channel: one frame status or delay measurement per transfer.
interface dtfd_rsp_if
   import dtfd_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [TIME_W-1:0]      delay_us;
   logic [FRAME_LEN_W-1:0] frame_length;
   logic [SEQ_W-1:0]       sequence_res;

   modport source (output valid, output status, output delay_us, output frame_length,
                   output sequence_res, input ready);
   modport sink   (input valid, input status, input delay_us, input frame_length,
                   input sequence_res, output ready);
endinterface

// ===== rtl/core/dtfd_csr.sv =====
// Configuration registers for frame length limits and the delimiter byte.
module dtfd_csr
   import dtfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an index outside the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_LENGTH: cfg_in.min_length = csr_wdata[CSR_LEN_W-1:0];
            CSR_MAX_LENGTH: cfg_in.max_length = csr_wdata[CSR_LEN_W-1:0];
            CSR_DELIMITER:  cfg_in.delimiter  = csr_wdata[BYTE_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length <= MIN_LENGTH_RESET;
         cfg_ff.max_length <= MAX_LENGTH_RESET;
         cfg_ff.delimiter  <= DELIMITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/dtfd_in_stage.sv =====
// Input register stage that captures one byte transfer per cycle while its held item moves on or it is empty.
module dtfd_in_stage
   import dtfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dtfd_req_if.sink    req_if,
   input  logic        consume,
   output in_item_type item
);

   in_item_type item_ff;
   in_item_type item_in;
   logic        take;

   // The stage is free when empty or when its item moves on this cycle.
   assign req_if.ready = !item_ff.valid || consume;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      item_in = item_ff;
      if (take) begin
         item_in.valid           = 1'b1;
         item_in.data_byte       = req_if.data_byte;
         item_in.arrival_time_us = req_if.arrival_time_us;
      end else if (consume) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid <= 1'b0;
      end else begin
         item_ff.valid <= item_in.valid;
      end
      item_ff.data_byte       <= item_in.data_byte;
      item_ff.arrival_time_us <= item_in.arrival_time_us;
   end

   assign item = item_ff;

endmodule

// ===== rtl/core/dtfd_frame_ctl.sv =====
// Frame tracking: timestamp capture, delimiter detection, length check and counting.
module dtfd_frame_ctl
   import dtfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  in_item_type item,
   input  logic        consume,
   output result_type  result
);

   logic [POS_W-1:0]  pos_ff;
   logic [POS_W-1:0]  pos_in;
   logic [TIME_W-1:0] origin_ff;
   logic [TIME_W-1:0] origin_in;
   logic [SEQ_W-1:0]  count_ff;
   logic [SEQ_W-1:0]  count_in;

   logic             in_stamp;
   logic             is_delim;
   logic             overflow;
   logic             in_range;
   logic             count_up;
   logic [LEN_W-1:0] len;
   logic [CMP_W-1:0] len_cmp;

   // Classify the byte by its place in the frame.
   assign in_stamp = pos_ff < POS_W'(STAMP_BYTES);
   assign is_delim = !in_stamp && (item.data_byte == cfg.delimiter);
   assign len      = LEN_W'(pos_ff) + LEN_W'(1);
   assign overflow = !in_stamp && !is_delim && (len == LEN_W'(MAX_FRAME));

   // Length check against the configured limits, delimiter included.
   assign len_cmp  = CMP_W'(len);
   assign in_range = !((len_cmp < CMP_W'(cfg.min_length)) ||
                       (len_cmp > CMP_W'(cfg.max_length)));
   assign count_up = is_delim && in_range;

   // Next state; the origin is shifted in low byte first.
   always_comb begin
      pos_in    = pos_ff;
      origin_in = origin_ff;
      count_in  = count_ff;
      if (consume) begin
         if (in_stamp) begin
            origin_in = {item.data_byte, origin_ff[TIME_W-1:BYTE_W]};
            pos_in    = pos_ff + POS_W'(1);
         end else if (is_delim || overflow) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
         if (count_up) begin
            count_in = count_ff + SEQ_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         origin_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         origin_ff <= origin_in;
         count_ff  <= count_in;
      end
   end

   // Result for a closed or dropped frame.
   always_comb begin
      result.valid        = consume && (is_delim || overflow);
      result.frame_length = FRAME_LEN_W'(len);
      result.sequence_res = count_up ? (count_ff + SEQ_W'(1)) : count_ff;
      result.delay_us     = '0;
      if (overflow) begin
         result.status = STATUS_OVERFLOW;
      end else if (in_range) begin
         result.status   = STATUS_MEASURE;
         result.delay_us = item.arrival_time_us - origin_ff;
      end else begin
         result.status = STATUS_BAD_LENGTH;
      end
   end

endmodule

// ===== rtl/core/dtfd_out_stage.sv =====
// Output register that holds one result until the sink takes it.
module dtfd_out_stage
   import dtfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       can_load,
   dtfd_rsp_if.source rsp_if
);

   result_type out_ff;
   result_type out_in;

   // A new result may enter when the register is empty or being drained.
   assign can_load = !out_ff.valid || rsp_if.ready;

   always_comb begin
      out_in = out_ff;
      if (can_load) begin
         out_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.status       <= out_in.status;
      out_ff.delay_us     <= out_in.delay_us;
      out_ff.frame_length <= out_in.frame_length;
      out_ff.sequence_res <= out_in.sequence_res;
   end

   assign rsp_if.valid        = out_ff.valid;
   assign rsp_if.status       = out_ff.status;
   assign rsp_if.delay_us     = out_ff.delay_us;
   assign rsp_if.frame_length = out_ff.frame_length;
   assign rsp_if.sequence_res = out_ff.sequence_res;

endmodule

// ===== rtl/core/delimited_timestamp_frame_delay.sv =====
// Top level of the timestamped frame delay meter.
//
// Channel   Direction  Contents
// req_if    in         data_byte, arrival_time_us (one stream byte per transfer)
// rsp_if    out        status, delay_us, frame_length, sequence_res
// csr_*     in         write enable, register index, write data
//
// One byte is accepted per cycle while no result is stalled in the output register. The
// byte that closes or drops a frame is held in the input register; its result is then
// loaded into the output register and presented on rsp_if. The frame state update is a
// single pass between the two registers.
// Reset is synchronous; it restores the register defaults and clears the frame state.
// A stalled result stays in the output register while the input register still
// takes one more byte; only then is req_if.ready dropped.
module delimited_timestamp_frame_delay
   import dtfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   dtfd_req_if.sink               req_if,
   dtfd_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type     cfg;
   in_item_type item;
   result_type  result;
   logic        can_load;
   logic        consume;

   // A registered byte moves on when the output register can take its result.
   assign consume = item.valid && can_load;

   dtfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtfd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .consume (consume),
      .item    (item)
   );

   dtfd_frame_ctl u_frame_ctl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .item    (item),
      .consume (consume),
      .result  (result)
   );

   dtfd_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== tb/dtfd_result_check.sv =====
// Result checker for the frame delay meter: predicts frame reports and compares them.
`timescale 1ns / 1ps
module dtfd_result_check
   import dtfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   dtfd_req_if                    req_if,
   dtfd_rsp_if                    rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatches,
   output int unsigned            outstanding,
   output logic [FRAME_LEN_W-1:0] frame_fill
);

   // One predicted frame report, in the order the block must deliver them.
   typedef struct packed {
      status_type             status;
      logic [TIME_W-1:0]      delay_us;
      logic [FRAME_LEN_W-1:0] frame_length;
      logic [SEQ_W-1:0]       sequence_res;
   } frame_report_type;

   frame_report_type frame_reports[$];

   // Shadow copy of the registers and of the frame state.
   logic [CSR_LEN_W-1:0]   min_len;
   logic [CSR_LEN_W-1:0]   max_len;
   logic [BYTE_W-1:0]      delim;
   logic [FRAME_LEN_W-1:0] fill;
   logic [TIME_W-1:0]      origin;
   logic [SEQ_W-1:0]       measure_count;

   // Advances the frame state by one byte and queues the report it causes, if any.
   task automatic step_frame(input logic [BYTE_W-1:0] value, input logic [TIME_W-1:0] now_us);
      logic [FRAME_LEN_W-1:0] len;
      frame_report_type       report;
      report.delay_us = '0;
      if (fill < STAMP_BYTES) begin
         // The first bytes of a frame are the origin stamp, even if one equals the delimiter.
         if (fill == 0) origin = '0;
         origin[fill[2:0]*8 +: 8] = value;
         fill = fill + 1'b1;
      end else if (value == delim) begin
         len = fill + 1'b1;
         fill = '0;
         if (len < min_len || len > max_len) begin
            report.status = STATUS_BAD_LENGTH;
         end else begin
            measure_count = measure_count + 1'b1;
            report.status = STATUS_MEASURE;
            report.delay_us = now_us - origin;
         end
         report.frame_length = len;
         report.sequence_res = measure_count;
         frame_reports.push_back(report);
      end else begin
         fill = fill + 1'b1;
         if (fill >= MAX_FRAME) begin
            // A full frame without a delimiter is dropped.
            fill = '0;
            report.status = STATUS_OVERFLOW;
            report.frame_length = FRAME_LEN_W'(MAX_FRAME);
            report.sequence_res = measure_count;
            frame_reports.push_back(report);
         end
      end
   endtask

   // Compares one result transfer with the oldest predicted report.
   task automatic check_result();
      frame_report_type want;
      if (frame_reports.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected result: status %0d delay %h length %0d sequence %0d",
                     $time, rsp_if.status, rsp_if.delay_us, rsp_if.frame_length,
                     rsp_if.sequence_res);
         return;
      end
      want = frame_reports.pop_front();
      if (rsp_if.status !== want.status || rsp_if.delay_us !== want.delay_us ||
          rsp_if.frame_length !== want.frame_length ||
          rsp_if.sequence_res !== want.sequence_res) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result mismatch", $time);
            $display("   expected status %s delay %h length %0d sequence %0d",
                     want.status.name(), want.delay_us, want.frame_length, want.sequence_res);
            $display("   actual   status %0d delay %h length %0d sequence %0d",
                     rsp_if.status, rsp_if.delay_us, rsp_if.frame_length,
                     rsp_if.sequence_res);
         end
      end
   endtask

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin
      if (reset) begin
         min_len = MIN_LENGTH_RESET;
         max_len = MAX_LENGTH_RESET;
         delim = DELIMITER_RESET;
         fill = '0;
         origin = '0;
         measure_count = '0;
         frame_reports.delete();
      end else begin
         if (rsp_if.valid && rsp_if.ready) check_result();
         if (req_if.valid && req_if.ready) step_frame(req_if.data_byte, req_if.arrival_time_us);
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MIN_LENGTH: min_len = csr_wdata[CSR_LEN_W-1:0];
               CSR_MAX_LENGTH: max_len = csr_wdata[CSR_LEN_W-1:0];
               CSR_DELIMITER:  delim = csr_wdata[BYTE_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = frame_reports.size();
      frame_fill = fill;
   end

endmodule

// ===== tb/delimited_timestamp_frame_delay_tb.sv =====
// Testbench top for the frame delay meter: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module delimited_timestamp_frame_delay_tb;
   import dtfd_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_BYTES    = 210;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned            mismatches;
   int unsigned            outstanding;
   logic [FRAME_LEN_W-1:0] frame_fill;

   // Stimulus state: idling modes, current delimiter and a running microsecond clock.
   bit                     src_idle = 1'b0;
   bit                     snk_idle = 1'b0;
   logic [BYTE_W-1:0]      cur_delim = DELIMITER_RESET;
   logic [TIME_W-1:0]      clock_us;
   int unsigned            bytes_sent = 0;
   int unsigned            idle_cycles = 0;

   dtfd_req_if req_if ();
   dtfd_rsp_if rsp_if ();

   delimited_timestamp_frame_delay dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dtfd_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .frame_fill  (frame_fill)
   );

   always #5 clock = ~clock;

   // Reset is held at the start of the run only, then released.
   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
   end

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("delimited_timestamp_frame_delay_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: in idle mode, drops ready for a random stall before each transfer.
   initial begin : result_sink
      int stall;
      rsp_if.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = snk_idle ? $urandom_range(0, 11) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid && rsp_if.ready));
         @(negedge clock);
      end
   end

   // Advances the microsecond clock a little and returns it.
   function automatic logic [TIME_W-1:0] tick();
      clock_us = clock_us + TIME_W'($urandom_range(1, 40));
      return clock_us;
   endfunction

   // Picks an origin stamp, usually shortly before now, sometimes holding the delimiter.
   function automatic logic [TIME_W-1:0] origin_for_frame();
      logic [TIME_W-1:0] origin;
      if ($urandom_range(0, 7) == 0) origin = {$urandom, $urandom};
      else origin = clock_us - TIME_W'($urandom_range(0, 100000));
      if ($urandom_range(0, 3) == 0) origin[8*$urandom_range(0, 7) +: 8] = cur_delim;
      return origin;
   endfunction

   // Offers one byte, after an optional gap, and returns at the falling edge after its transfer.
   task automatic send_byte(input logic [BYTE_W-1:0] value, input logic [TIME_W-1:0] stamp_us);
      int gap;
      gap = src_idle ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= value;
      req_if.arrival_time_us <= stamp_us;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
      @(negedge clock);
   endtask

   // Sends a frame of len bytes: the stamp, filler without the delimiter and, if closed,
   // the delimiter as its last byte.
   task automatic send_frame(input int len, input logic [TIME_W-1:0] origin,
                             input logic [TIME_W-1:0] close_us, input bit closed);
      logic [BYTE_W-1:0] filler;
      for (int pos = 0; pos < len; pos++) begin
         if (closed && pos == len - 1) begin
            send_byte(cur_delim, close_us);
         end else if (pos < STAMP_BYTES) begin
            send_byte(origin[8*pos +: 8], tick());
         end else begin
            do filler = BYTE_W'($urandom_range(0, 255)); while (filler == cur_delim);
            send_byte(filler, tick());
         end
      end
   endtask

   // Finishes a frame left open by noise or a broken frame, so the next one starts clean.
   task automatic close_open_frame();
      if (frame_fill == 0) return;
      while (frame_fill < STAMP_BYTES) send_byte(BYTE_W'($urandom_range(0, 255)), tick());
      send_byte(cur_delim, tick());
   endtask

   // Holds the input off until every predicted result has been delivered.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Writes all three registers while the block is idle.
   task automatic write_config(input logic [CSR_DATA_W-1:0] min_len,
                               input logic [CSR_DATA_W-1:0] max_len,
                               input logic [CSR_DATA_W-1:0] delim_word);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MIN_LENGTH;
      csr_wdata <= min_len;
      @(negedge clock);
      csr_index <= CSR_MAX_LENGTH;
      csr_wdata <= max_len;
      @(negedge clock);
      csr_index <= CSR_DELIMITER;
      csr_wdata <= delim_word;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_delim = delim_word[BYTE_W-1:0];
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] origin;
      logic [TIME_W-1:0] close_us;
      logic [BYTE_W-1:0] delim;
      int                lo;
      int                hi;
      int                len;
      int unsigned       phase_start;

      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.arrival_time_us = '0;
      clock_us = {$urandom, $urandom};
      while (reset) @(negedge clock);

      // Reset registers: a short frame with the delimiter inside its stamp is too short.
      origin = 64'h0123_4567_89ab_cdef;
      origin[24 +: 8] = DELIMITER_RESET;
      send_frame(9, origin, tick(), 1'b1);

      // Shortest legal frame, with delays that wrap around both ends of the time range.
      write_config(13'd9, 13'd9, CSR_DATA_W'(DELIMITER_RESET));
      send_frame(9, '1, '0, 1'b1);
      send_frame(9, '0, '1, 1'b1);

      // Random phases: mostly well-formed frames near the length limits, some noise.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         lo = $urandom_range(9, 28);
         hi = $urandom_range(9, 40);
         case (phase)
            1:       delim = 8'h00;
            2:       delim = 8'hff;
            default: delim = BYTE_W'($urandom_range(0, 255));
         endcase
         write_config(CSR_DATA_W'(lo), CSR_DATA_W'(hi), {5'($urandom_range(0, 31)), delim});
         src_idle = (phase == 0) || (phase != 3 && $urandom_range(0, 3) != 0);
         snk_idle = (phase == 0) || (phase != 3 && $urandom_range(0, 3) != 0);
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            if (phase != 0 && phase != 3 && $urandom_range(0, 9) == 0) begin
               src_idle = !src_idle;
               snk_idle = $urandom_range(0, 1);
            end
            case ($urandom_range(0, 9))
               0: begin
                  // Noise: raw bytes with arbitrary times.
                  repeat ($urandom_range(1, 6))
                     send_byte(BYTE_W'($urandom_range(0, 255)), {$urandom, $urandom});
               end
               1: begin
                  // A frame cut off before its delimiter.
                  close_open_frame();
                  send_frame($urandom_range(1, 30), origin_for_frame(), '0, 1'b0);
               end
               default: begin
                  close_open_frame();
                  case ($urandom_range(0, 5))
                     0:       len = lo - 1;
                     1:       len = lo;
                     2:       len = hi;
                     3:       len = hi + 1;
                     default: len = $urandom_range(9, 44);
                  endcase
                  if (len < 9) len = 9;
                  origin = origin_for_frame();
                  close_us = ($urandom_range(0, 7) == 0) ? {$urandom, $urandom} : tick();
                  send_frame(len, origin, close_us, 1'b1);
               end
            endcase
         end
      end

      // Largest sizes: a delimiter in the last slot, an overflow drop, then a short frame.
      write_config(CSR_DATA_W'(MAX_FRAME), CSR_DATA_W'(MAX_FRAME), 13'h1fff);
      src_idle = 1'b0;
      snk_idle = 1'b1;
      close_open_frame();
      send_frame(MAX_FRAME, origin_for_frame(), tick(), 1'b1);
      send_frame(MAX_FRAME, origin_for_frame(), '0, 1'b0);
      src_idle = 1'b1;
      send_frame(9, origin_for_frame(), tick(), 1'b1);

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0) begin
         $display("delimited_timestamp_frame_delay_tb passed");
      end else begin
         $display("delimited_timestamp_frame_delay_tb failed");
      end
      $finish;
   end

endmodule
